>>> hdl/hdip_pkg.sv
package hdip_pkg;

  // prefix byte fields
  localparam logic [7:0] TAG_MASK           = 8'b1111_1100;
  localparam logic [7:0] SIZE_MASK          = 8'b0000_0011;
  localparam logic [1:0] SIZE_CODE_FOUR     = 2'b11;

  // tags with side effects
  localparam logic [7:0] TAG_USAGE          = 8'h08;
  localparam logic [7:0] TAG_COLLECTION     = 8'hA0;
  localparam logic [7:0] TAG_END_COLLECTION = 8'hC0;

  // one processed word handed from the assembler to the tracker
  typedef struct packed {
    logic        valid;  // a word was processed this cycle
    logic        clear;  // start of descriptor seen on this word
    logic        done;   // an item completed
    logic [7:0]  tag;
    logic [2:0]  size;
    logic [31:0] data;
  } step_t;

endpackage

>>> hdl/hid_descriptor_item_parser.sv
// path: the word that completes an item passes the input register, then the result register
// throughput: one descriptor word per cycle while the result register is empty or being taken
// results: zero or one item per word, held in a result register until taken
// reset: synchronous active-low rst_n clears partial item, depth and usage latch
module hid_descriptor_item_parser
  import hdip_pkg::*;
#(
  parameter int MAX_DEPTH = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_descriptor,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_item_tag,
  output logic [2:0]  out_item_size,
  output logic [31:0] out_item_data,
  output logic [7:0]  out_nesting_level,
  output logic [31:0] out_device_type,
  output logic        out_type_valid
);

  step_t step;
  logic  adv;

  // byte register and item assembly
  hdip_assembler u_assembler (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_data_byte           (in_data_byte),
    .in_start_of_descriptor (in_start_of_descriptor),
    .in_last_byte           (in_last_byte),
    .adv_i                  (adv),
    .step_o                 (step)
  );

  // nesting, usage latch and result register
  hdip_tracker #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_tracker (
    .clk               (clk),
    .rst_n             (rst_n),
    .step_i            (step),
    .adv_o             (adv),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item_tag      (out_item_tag),
    .out_item_size     (out_item_size),
    .out_item_data     (out_item_data),
    .out_nesting_level (out_nesting_level),
    .out_device_type   (out_device_type),
    .out_type_valid    (out_type_valid)
  );

endmodule

>>> hdl/hdip_assembler.sv
module hdip_assembler
  import hdip_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_descriptor,
  input  logic        in_last_byte,
  input  logic        adv_i,
  output step_t       step_o
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_sof_r;
  logic       s1_last_r;

  logic [2:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  held_tag_r, held_tag_nxt;
  logic [2:0]  held_size_r, held_size_nxt;
  logic [31:0] data_accum_r, data_accum_nxt;
  logic [1:0]  byte_index_r, byte_index_nxt;

  logic        fire;
  logic [2:0]  bl_eff;
  logic [7:0]  tag_eff;
  logic [2:0]  size_eff;
  logic [31:0] accum_eff;
  logic [1:0]  idx_eff;
  logic [7:0]  pfx_tag;
  logic [2:0]  pfx_size;
  logic [31:0] accum_new;
  logic [2:0]  bl_dec;

  assign fire     = s1_valid_r && adv_i;
  assign in_ready = !s1_valid_r || adv_i;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_sof_r  <= in_start_of_descriptor;
      s1_last_r <= in_last_byte;
    end
  end

  // partial item, dropped when the word starts a descriptor
  assign bl_eff    = s1_sof_r ? 3'd0  : bytes_left_r;
  assign tag_eff   = s1_sof_r ? 8'd0  : held_tag_r;
  assign size_eff  = s1_sof_r ? 3'd0  : held_size_r;
  assign accum_eff = s1_sof_r ? 32'd0 : data_accum_r;
  assign idx_eff   = s1_sof_r ? 2'd0  : byte_index_r;

  assign pfx_tag   = s1_byte_r & TAG_MASK;
  assign pfx_size  = ((s1_byte_r & SIZE_MASK) == {6'd0, SIZE_CODE_FOUR}) ? 3'd4
                     : {1'b0, s1_byte_r[1:0]};
  assign accum_new = accum_eff | ({24'd0, s1_byte_r} << {idx_eff, 3'b000});
  assign bl_dec    = bl_eff - 3'd1;

  // item assembly
  always_comb begin
    bytes_left_nxt = bytes_left_r;
    held_tag_nxt   = held_tag_r;
    held_size_nxt  = held_size_r;
    data_accum_nxt = data_accum_r;
    byte_index_nxt = byte_index_r;
    step_o         = '0;
    step_o.valid   = fire;
    step_o.clear   = s1_sof_r;
    if (fire) begin
      if (bl_eff == 3'd0) begin
        if (pfx_size == 3'd0) begin
          // item without data completes on its prefix
          step_o.done    = 1'b1;
          step_o.tag     = pfx_tag;
          bytes_left_nxt = 3'd0;
          held_tag_nxt   = 8'd0;
          held_size_nxt  = 3'd0;
          data_accum_nxt = 32'd0;
          byte_index_nxt = 2'd0;
        end else if (s1_last_r) begin
          bytes_left_nxt = 3'd0;
          held_tag_nxt   = 8'd0;
          held_size_nxt  = 3'd0;
          data_accum_nxt = 32'd0;
          byte_index_nxt = 2'd0;
        end else begin
          bytes_left_nxt = pfx_size;
          held_tag_nxt   = pfx_tag;
          held_size_nxt  = pfx_size;
          data_accum_nxt = 32'd0;
          byte_index_nxt = 2'd0;
        end
      end else if (bl_dec == 3'd0) begin
        // last data byte
        step_o.done    = 1'b1;
        step_o.tag     = tag_eff;
        step_o.size    = size_eff;
        step_o.data    = accum_new;
        bytes_left_nxt = 3'd0;
        held_tag_nxt   = 8'd0;
        held_size_nxt  = 3'd0;
        data_accum_nxt = 32'd0;
        byte_index_nxt = 2'd0;
      end else if (s1_last_r) begin
        // truncated item is dropped
        bytes_left_nxt = 3'd0;
        held_tag_nxt   = 8'd0;
        held_size_nxt  = 3'd0;
        data_accum_nxt = 32'd0;
        byte_index_nxt = 2'd0;
      end else begin
        bytes_left_nxt = bl_dec;
        held_tag_nxt   = tag_eff;
        held_size_nxt  = size_eff;
        data_accum_nxt = accum_new;
        byte_index_nxt = idx_eff + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 3'd0;
      held_tag_r   <= 8'd0;
      held_size_r  <= 3'd0;
      data_accum_r <= 32'd0;
      byte_index_r <= 2'd0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      held_tag_r   <= held_tag_nxt;
      held_size_r  <= held_size_nxt;
      data_accum_r <= data_accum_nxt;
      byte_index_r <= byte_index_nxt;
    end
  end

`ifndef SYNTHESIS
  // never more than four data bytes outstanding
  a_bytes_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r <= 3'd4)
    else $error("bytes_left out of range");

  // position plus bytes still due always equals the item size
  a_index_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r != 3'd0 |-> ({1'b0, byte_index_r} + bytes_left_r) == held_size_r)
    else $error("byte index and bytes left disagree");

  // a completed item never carries a size outside 0, 1, 2, 4
  a_done_size: assert property (@(posedge clk) disable iff (!rst_n)
    step_o.done |-> (step_o.size == 3'd0 || step_o.size == 3'd1 ||
                     step_o.size == 3'd2 || step_o.size == 3'd4))
    else $error("bad item size");
`endif

endmodule

>>> hdl/hdip_tracker.sv
module hdip_tracker
  import hdip_pkg::*;
#(
  parameter int MAX_DEPTH = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  step_t       step_i,
  output logic        adv_o,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_item_tag,
  output logic [2:0]  out_item_size,
  output logic [31:0] out_item_data,
  output logic [7:0]  out_nesting_level,
  output logic [31:0] out_device_type,
  output logic        out_type_valid
);

  localparam logic [7:0] MaxDepthC = 8'(MAX_DEPTH);

  logic [7:0]  depth_r, depth_nxt;
  logic        usage_r, usage_nxt;
  logic [31:0] ltype_r, ltype_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  level_nxt;

  logic [7:0]  depth_eff;
  logic        usage_eff;
  logic [31:0] ltype_eff;

  assign adv_o = !out_valid_r || out_ready;

  assign depth_eff = step_i.clear ? 8'd0  : depth_r;
  assign usage_eff = step_i.clear ? 1'b0  : usage_r;
  assign ltype_eff = step_i.clear ? 32'd0 : ltype_r;

  // depth and usage latch update
  always_comb begin
    depth_nxt = depth_r;
    usage_nxt = usage_r;
    ltype_nxt = ltype_r;
    level_nxt = depth_eff;
    if (step_i.valid) begin
      depth_nxt = depth_eff;
      usage_nxt = usage_eff;
      ltype_nxt = ltype_eff;
      if (step_i.done) begin
        if (step_i.tag == TAG_COLLECTION) begin
          if (depth_eff < MaxDepthC) begin
            depth_nxt = depth_eff + 8'd1;
          end
        end else if (step_i.tag == TAG_END_COLLECTION) begin
          if (depth_eff != 8'd0) begin
            depth_nxt = depth_eff - 8'd1;
          end
          level_nxt = depth_nxt;
        end else if (step_i.tag == TAG_USAGE) begin
          if (!usage_eff) begin
            usage_nxt = 1'b1;
            ltype_nxt = step_i.data;
          end
        end
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_i.valid && step_i.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= 8'd0;
      usage_r     <= 1'b0;
      ltype_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      usage_r     <= usage_nxt;
      ltype_r     <= ltype_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i.valid && step_i.done) begin
      out_item_tag      <= step_i.tag;
      out_item_size     <= step_i.size;
      out_item_data     <= step_i.data;
      out_nesting_level <= level_nxt;
      out_device_type   <= ltype_nxt;
      out_type_valid    <= usage_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // depth stays within its limit
  a_depth_limit: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= MaxDepthC)
    else $error("depth above limit");

  // the usage latch drops only on a start of descriptor
  a_usage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(usage_r) |-> $past(step_i.valid && step_i.clear))
    else $error("usage latch lost");

  // a latched type is only ever held with the latch set
  a_type_needs_latch: assert property (@(posedge clk) disable iff (!rst_n)
    ltype_r != 32'd0 |-> usage_r)
    else $error("device type without usage latch");
`endif

endmodule
